### rtl/fsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_pkg: shared types for the frame sequence playhead
// Request kind codes, playback modes and the result record that travels
// from the playhead logic through the output skid buffer.
// ----------------------------------------------------------------------------
package fsp_pkg;

    // Request kinds on the input channel. Code 7 is unused and ignored.
    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_PLAY      = 3'd1,
        KIND_REVERSE   = 3'd2,
        KIND_STOP      = 3'd3,
        KIND_RESTART   = 3'd4,
        KIND_GOTO_PLAY = 3'd5,
        KIND_GOTO_STOP = 3'd6
    } kind_t;

    // Playback modes as reported on the result channel.
    typedef enum logic [1:0] {
        MODE_FWD  = 2'd0,
        MODE_REV  = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_FRAME_DELAY    = 2'd0,
        REG_FRAME_COUNT    = 2'd1,
        REG_LOOP_ON_FINISH = 2'd2,
        REG_LOOP_REPEATS   = 2'd3
    } reg_index_t;

    localparam int FRAME_INDEX_W = 10;
    localparam int FRAME_COUNT_W = 11;
    localparam int FRAME_NUM_W   = 12;
    localparam int DELAY_REG_W   = 16;
    localparam int REPEATS_W     = 8;
    localparam int CFG_DATA_W    = 16;

    // One result record.
    typedef struct packed {
        logic [FRAME_INDEX_W-1:0] frame_index;
        logic                     loop_complete;
        logic [1:0]               play_mode;
    } result_t;

endpackage

### rtl/fsp_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsp_skid: two-entry output buffer for result records
// Holds the presented result and one more, so the upstream side still hands
// over one further request while the receiver stalls.
// ----------------------------------------------------------------------------
module fsp_skid
    import fsp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    // Only a full skid slot blocks the upstream side.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control state: which of the two slots hold a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload slots follow the same moves without a reset.
    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else begin
                out_data_reg <= in_data;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

### rtl/frame_sequence_playhead.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_sequence_playhead: animation playhead sequencer
// Ticks advance the playhead after a programmable delay; commands play,
// reverse, stop, restart or jump to a clamped frame.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is a tick or a command (s_kind, with
//   s_frame_number as the target of the goto commands). Every accepted
//   request yields exactly one result on the m_ channel: the playhead
//   frame, the loop-complete flag and the playback mode after the request.
//   A request is taken in every cycle in which s_ready is high. The playhead
//   state updates at the accepting edge and, while the receiver does not
//   stall, its result is presented from the next cycle on.
//   The results pass through a two-entry output buffer: while the receiver
//   stalls, one more request is still taken, then s_ready drops until the
//   receiver takes a result. Nothing is lost or repeated.
//   Reset clears the playhead to frame 0, the mode to forward, the flag
//   and the tick count, and loads frame_delay 1, frame_count 1,
//   loop_on_finish 1 and loop_repeats 0 (so the loop budget is 0).
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and are meant to be issued while no request is in flight.
// ----------------------------------------------------------------------------
module frame_sequence_playhead
    import fsp_pkg::*;
#(
    parameter int MAX_FRAMES = 1024,
    parameter int DELAY_BITS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // Configuration write port
    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // Request channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_kind,
    input  logic signed [FRAME_NUM_W-1:0] s_frame_number,
    // Result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [FRAME_INDEX_W-1:0] m_frame_index,
    output logic                     m_loop_complete,
    output logic [1:0]               m_play_mode
);

    localparam int PH_W  = $clog2(MAX_FRAMES);
    localparam int CMP_W = (DELAY_BITS > DELAY_REG_W) ? DELAY_BITS : DELAY_REG_W;
    localparam logic [DELAY_BITS-1:0] TICK_MAX = '1;

    // Last valid frame index for a frame count, with 0 read as 1 and
    // anything above the frame capacity read as the capacity.
    function automatic logic [PH_W-1:0] last_of(input logic [FRAME_COUNT_W-1:0] count);
        logic [31:0] n;
        n = 32'(count);
        if (n == 32'd0) begin
            n = 32'd1;
        end
        if (n > 32'(MAX_FRAMES)) begin
            n = 32'(MAX_FRAMES);
        end
        return PH_W'(n - 32'd1);
    endfunction

    // Configuration registers
    logic [DELAY_REG_W-1:0]   frame_delay_reg;
    logic [FRAME_COUNT_W-1:0] frame_count_reg;
    logic                     loop_on_finish_reg;
    logic [REPEATS_W-1:0]     loop_repeats_reg;

    // Playhead state
    logic [PH_W-1:0]       playhead_reg, playhead_next;
    mode_t                 mode_reg, mode_next;
    logic                  complete_flag_reg, complete_flag_next;
    logic [REPEATS_W-1:0]  loops_left_reg, loops_left_next;
    logic [DELAY_BITS-1:0] ticks_reg, ticks_next;

    logic                   accept;
    logic [PH_W-1:0]        last_idx;
    logic [DELAY_BITS-1:0]  ticks_inc;
    logic [DELAY_REG_W-1:0] need;
    logic                   step_due;
    logic [PH_W-1:0]        goto_target;
    logic                   loops_avail;
    result_t                result;
    result_t                m_result;
    logic                   res_ready;

    assign accept   = s_valid && s_ready;
    assign last_idx = last_of(frame_count_reg);

    // Saturating tick count and the step decision for a tick.
    assign ticks_inc = (ticks_reg == TICK_MAX) ? ticks_reg : ticks_reg + 1'b1;
    assign need      = (frame_delay_reg == '0) ? DELAY_REG_W'(1) : frame_delay_reg;
    assign step_due  = (mode_reg != MODE_STOP) && (CMP_W'(ticks_inc) >= CMP_W'(need));
    assign loops_avail = loops_left_reg > REPEATS_W'(1);

    // Goto target clamped into 0..last; negative targets go to frame 0.
    always_comb begin
        if (s_frame_number[FRAME_NUM_W-1]) begin
            goto_target = '0;
        end else if (32'(s_frame_number[FRAME_NUM_W-2:0]) > 32'(last_idx)) begin
            goto_target = last_idx;
        end else begin
            goto_target = PH_W'(s_frame_number[FRAME_NUM_W-2:0]);
        end
    end

    // Next playhead state from a configuration write or an accepted request.
    always_comb begin
        playhead_next      = playhead_reg;
        mode_next          = mode_reg;
        complete_flag_next = complete_flag_reg;
        loops_left_next    = loops_left_reg;
        ticks_next         = ticks_reg;
        priority if (cfg_we) begin
            if (cfg_index == REG_FRAME_COUNT) begin
                if (playhead_reg > last_of(cfg_data[FRAME_COUNT_W-1:0])) begin
                    playhead_next = last_of(cfg_data[FRAME_COUNT_W-1:0]);
                end
            end else if (cfg_index == REG_LOOP_REPEATS) begin
                loops_left_next = cfg_data[REPEATS_W-1:0];
            end
        end else if (accept) begin
            unique case (kind_t'(s_kind))
                KIND_TICK: begin
                    ticks_next = ticks_inc;
                    if (step_due) begin
                        ticks_next = '0;
                        if (mode_reg == MODE_FWD) begin
                            // Forward: advance, or handle the sequence end.
                            if (playhead_reg < last_idx) begin
                                playhead_next = playhead_reg + 1'b1;
                            end else begin
                                complete_flag_next = 1'b1;
                                if (loop_on_finish_reg) begin
                                    playhead_next = '0;
                                end else if (loops_avail) begin
                                    loops_left_next = loops_left_reg - 1'b1;
                                    playhead_next   = '0;
                                end else begin
                                    playhead_next = last_idx;
                                end
                            end
                        end else begin
                            // Reverse: back up, or handle the sequence start.
                            if (playhead_reg != '0) begin
                                playhead_next = (playhead_reg > last_idx) ?
                                                last_idx : playhead_reg - 1'b1;
                            end else begin
                                complete_flag_next = 1'b1;
                                if (loop_on_finish_reg) begin
                                    playhead_next = last_idx;
                                end else if (loops_avail) begin
                                    loops_left_next = loops_left_reg - 1'b1;
                                    playhead_next   = last_idx;
                                end else begin
                                    playhead_next = '0;
                                end
                            end
                        end
                    end
                end
                KIND_PLAY: begin
                    complete_flag_next = 1'b0;
                    mode_next          = MODE_FWD;
                end
                KIND_REVERSE: begin
                    complete_flag_next = 1'b0;
                    mode_next          = MODE_REV;
                end
                KIND_STOP: begin
                    complete_flag_next = 1'b0;
                    mode_next          = MODE_STOP;
                end
                KIND_RESTART: begin
                    complete_flag_next = 1'b0;
                    mode_next          = MODE_FWD;
                    playhead_next      = '0;
                    loops_left_next    = loop_repeats_reg;
                end
                KIND_GOTO_PLAY: begin
                    complete_flag_next = 1'b0;
                    mode_next          = MODE_FWD;
                    playhead_next      = goto_target;
                end
                KIND_GOTO_STOP: begin
                    complete_flag_next = 1'b0;
                    mode_next          = MODE_STOP;
                    playhead_next      = goto_target;
                end
                default: begin
                    // Unused kind: state is left as it is.
                end
            endcase
        end else begin
            // No write and no request: the state holds.
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_delay_reg    <= DELAY_REG_W'(1);
            frame_count_reg    <= FRAME_COUNT_W'(1);
            loop_on_finish_reg <= 1'b1;
            loop_repeats_reg   <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_FRAME_DELAY:    frame_delay_reg    <= cfg_data[DELAY_REG_W-1:0];
                REG_FRAME_COUNT:    frame_count_reg    <= cfg_data[FRAME_COUNT_W-1:0];
                REG_LOOP_ON_FINISH: loop_on_finish_reg <= cfg_data[0];
                REG_LOOP_REPEATS:   loop_repeats_reg   <= cfg_data[REPEATS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Playhead state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            playhead_reg      <= '0;
            mode_reg          <= MODE_FWD;
            complete_flag_reg <= 1'b0;
            loops_left_reg    <= '0;
            ticks_reg         <= '0;
        end else begin
            playhead_reg      <= playhead_next;
            mode_reg          <= mode_next;
            complete_flag_reg <= complete_flag_next;
            loops_left_reg    <= loops_left_next;
            ticks_reg         <= ticks_next;
        end
    end

    // Result record built from the state after the request.
    assign result.frame_index   = FRAME_INDEX_W'(playhead_next);
    assign result.loop_complete = complete_flag_next;
    assign result.play_mode     = mode_next;

    fsp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .in_ready  (res_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_result)
    );

    assign s_ready         = res_ready;
    assign m_frame_index   = m_result.frame_index;
    assign m_loop_complete = m_result.loop_complete;
    assign m_play_mode     = m_result.play_mode;

    // The request side only blocks while a result is waiting downstream.
    a_ready_blocks_only_on_result: assert property (
        @(posedge aclk) disable iff (!aresetn) !s_ready |-> m_valid
    ) else $error("s_ready low with no result presented");

    // The playhead never points past the last frame of the sequence.
    a_playhead_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn) playhead_reg <= last_idx
    ) else $error("playhead beyond last frame");

    // A tick while stopped never moves the playhead.
    a_stopped_tick_holds: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_we && s_kind == KIND_TICK && mode_reg == MODE_STOP)
        |=> $stable(playhead_reg)
    ) else $error("playhead moved on a tick while stopped");

    // Any command clears the loop-complete flag.
    a_command_clears_flag: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (accept && !cfg_we && s_kind != KIND_TICK && s_kind != 3'(7))
        |=> !complete_flag_reg
    ) else $error("command left the loop-complete flag set");

endmodule
